// ===== rtl/bffa_pkg.sv =====
// Shared constants, types and helpers for the bitmap first-free allocator.
// No dependencies.
package bffa_pkg;

    localparam int MAP_BITS  = 8192;
    localparam int WORD_BITS = 64;
    localparam int WORDS     = MAP_BITS / WORD_BITS;
    localparam int WORD_AW   = $clog2(WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_AW    = WORD_AW + BIT_W;
    localparam int MEM_AW    = WORD_AW + 1;      // pool bit on top
    localparam int NUM_W     = 14;
    localparam int CNT_W     = NUM_W + 1 - BIT_W;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_INODE_LIMIT = 1'b0;
    localparam logic REG_BLOCK_LIMIT = 1'b1;

    localparam logic [NUM_W-1:0] LIMIT_RESET = NUM_W'(8192);

    typedef struct packed {
        logic                 rd_en;
        logic [MEM_AW-1:0]    rd_addr;
        logic                 wr_en;
        logic [MEM_AW-1:0]    wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } mem_req_t;

    // lowest set bit of a word
    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

endpackage

// ===== rtl/bffa_map_mem.sv =====
// Bitmap word memory for both pools, one read and one write port.
// Depends on bffa_pkg.
module bffa_map_mem (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bffa_pkg::mem_req_t              req,
    output logic [bffa_pkg::WORD_BITS-1:0]  rd_data
);
    import bffa_pkg::*;

    localparam int DEPTH = 2 * WORDS;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    // word that was never written reads as all free
    always_ff @(posedge aclk) begin
        if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en) rd_data_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.wr_en) valid_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en) rd_vld_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/bitmap_first_free_allocator.sv =====
// Bitmap first-free allocator: inode and block pools in one word memory.
// Allocate: words (64 bits each) are scanned in order from word 0 up to the limit
//   until one holds a free bit; when the pool is full, every word below the limit is scanned.
// Free: the word is read, then written back; out of range or zero limit: no memory access.
//   The next request is accepted once the result is in the output register; the word scan sets the pace.
// Reset (aresetn, synchronous, active low) marks all words free at once.
module bitmap_first_free_allocator (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic                         s_pool,
    input  logic [bffa_pkg::NUM_W-1:0]   s_number,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bffa_pkg::NUM_W-1:0]   m_granted,
    output logic [1:0]                   m_status,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import bffa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_OUT
    } state_t;

    // ---------------- configuration registers ----------------
    logic [NUM_W-1:0] inode_limit_reg, block_limit_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inode_limit_reg <= LIMIT_RESET;
            block_limit_reg <= LIMIT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_INODE_LIMIT) inode_limit_reg <= pwdata[NUM_W-1:0];
            else                             block_limit_reg <= pwdata[NUM_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_INODE_LIMIT) ? {(32 - NUM_W)'(0), inode_limit_reg}
                                                  : {(32 - NUM_W)'(0), block_limit_reg};

    // ---------------- datapath / control registers ----------------
    state_t               state_reg, state_next;
    logic                 pool_reg, pool_next;
    logic [MAP_AW-1:0]    idx_reg, idx_next;         // bit index of a free
    logic [CNT_W-1:0]     words_end_reg, words_end_next;
    logic [CNT_W-1:0]     lim_word_reg, lim_word_next;
    logic [BIT_W-1:0]     lim_bit_reg, lim_bit_next;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic [WORD_AW-1:0]   eval_word_reg, eval_word_next;
    logic                 pend_reg, pend_next;       // read data for eval_word present
    logic [NUM_W-1:0]     res_granted_reg, res_granted_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [NUM_W-1:0]     m_granted_reg, m_granted_next;
    logic [1:0]           m_status_reg, m_status_next;

    mem_req_t             mem_req;
    logic [WORD_BITS-1:0] rd_data;

    bffa_map_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // effective limit of the requested pool, saturated at the map size
    logic [NUM_W-1:0]     sel_limit, eff_lim;
    logic [NUM_W:0]       lim_ext, lim_round;
    logic [NUM_W-1:0]     num_m1;
    logic [WORD_BITS-1:0] word_mask, free_vec;
    logic [BIT_W-1:0]     hit_bit;

    always_comb begin
        sel_limit = s_pool ? block_limit_reg : inode_limit_reg;
        eff_lim   = (32'(sel_limit) > MAP_BITS) ? NUM_W'(MAP_BITS) : sel_limit;
        lim_ext   = {1'b0, eff_lim};
        lim_round = lim_ext + (NUM_W + 1)'(WORD_BITS - 1);
        num_m1    = s_number - NUM_W'(1);

        // bits of the word under evaluation that lie below the limit
        if (CNT_W'(eval_word_reg) < lim_word_reg) word_mask = '1;
        else word_mask = (WORD_BITS'(1) << lim_bit_reg) - WORD_BITS'(1);
        free_vec = ~rd_data & word_mask;
        hit_bit  = first_set(free_vec);
    end

    always_comb begin
        state_next       = state_reg;
        pool_next        = pool_reg;
        idx_next         = idx_reg;
        words_end_next   = words_end_reg;
        lim_word_next    = lim_word_reg;
        lim_bit_next     = lim_bit_reg;
        issue_cnt_next   = issue_cnt_reg;
        eval_word_next   = eval_word_reg;
        pend_next        = 1'b0;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg;
        m_granted_next   = m_granted_reg;
        m_status_next    = m_status_reg;
        mem_req          = '0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    pool_next        = s_pool;
                    res_granted_next = '0;
                    res_status_next  = ST_OK;
                    if (s_mode == MODE_ALLOC) begin
                        if (eff_lim == '0) begin
                            res_status_next = ST_FULL;
                            state_next      = S_OUT;
                        end else begin
                            words_end_next = CNT_W'(lim_round >> BIT_W);
                            lim_word_next  = CNT_W'(lim_ext >> BIT_W);
                            lim_bit_next   = eff_lim[BIT_W-1:0];
                            issue_cnt_next = '0;
                            state_next     = S_SCAN;
                        end
                    end else begin
                        if (s_number == '0 || s_number > eff_lim) begin
                            res_status_next = ST_RANGE;
                            state_next      = S_OUT;
                        end else begin
                            idx_next   = num_m1[MAP_AW-1:0];
                            state_next = S_FREE_RD;
                        end
                    end
                end
            end
            S_SCAN: begin
                // one word read issued per cycle, evaluated in the cycle after
                if (issue_cnt_reg < words_end_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = {pool_reg, issue_cnt_reg[WORD_AW-1:0]};
                    issue_cnt_next  = issue_cnt_reg + CNT_W'(1);
                    pend_next       = 1'b1;
                    eval_word_next  = issue_cnt_reg[WORD_AW-1:0];
                end
                if (pend_reg) begin
                    if (|free_vec) begin
                        mem_req.wr_en    = 1'b1;
                        mem_req.wr_addr  = {pool_reg, eval_word_reg};
                        mem_req.wr_data  = rd_data | (WORD_BITS'(1) << hit_bit);
                        res_granted_next = NUM_W'({eval_word_reg, hit_bit}) + NUM_W'(1);
                        res_status_next  = ST_OK;
                        state_next       = S_OUT;
                    end else if (CNT_W'(eval_word_reg) + CNT_W'(1) == words_end_reg) begin
                        res_status_next = ST_FULL;
                        state_next      = S_OUT;
                    end
                end
            end
            S_FREE_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = {pool_reg, idx_reg[MAP_AW-1:BIT_W]};
                state_next      = S_FREE_WR;
            end
            S_FREE_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {pool_reg, idx_reg[MAP_AW-1:BIT_W]};
                mem_req.wr_data = rd_data & ~(WORD_BITS'(1) << idx_reg[BIT_W-1:0]);
                state_next      = S_OUT;
            end
            S_OUT: begin
                // hand the result to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_status_next  = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        pool_reg        <= pool_next;
        idx_reg         <= idx_next;
        words_end_reg   <= words_end_next;
        lim_word_reg    <= lim_word_next;
        lim_bit_reg     <= lim_bit_next;
        issue_cnt_reg   <= issue_cnt_next;
        eval_word_reg   <= eval_word_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        m_granted_reg   <= m_granted_next;
        m_status_reg    <= m_status_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_granted = m_granted_reg;
    assign m_status  = m_status_reg;

endmodule

// ===== rtl/bffa_checker.sv =====
// Port-level checks for the bitmap first-free allocator, bound to the top level.
// Depends on bffa_pkg and bitmap_first_free_allocator.
module bffa_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [bffa_pkg::NUM_W-1:0]   m_granted,
    input logic [1:0]                   m_status
);
    import bffa_pkg::*;

    // failed requests never carry a number
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL || m_status == ST_RANGE) |-> m_granted == '0)
        else $error("failed request carries a granted number");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_FULL || m_status == ST_RANGE))
        else $error("undefined status code");

    // one request in flight: no accept on the cycle right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one still in work");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted) && $stable(m_status))
        else $error("stalled result changed");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_granted (m_granted),
    .m_status  (m_status)
);

// ===== tb/sv/bitmap_first_free_allocator_tb.sv =====
// Self-checking testbench for the bitmap first-free allocator (inode and block pools).
// Depends on rtl/bffa_pkg.sv and rtl/bitmap_first_free_allocator.sv; reads no files.
`timescale 1ns / 100ps

module bitmap_first_free_allocator_tb;
    import bffa_pkg::*;

    // pool select values carried on s_pool
    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_BLOCK = 1'b1;

    // Worst item is a full scan plus stalls on both sides; the whole run
    // stays far below this even with every scan hitting the limit.
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int DRAIN_CYCLES  = 150;      // covers the longest scan
    localparam int HOLD_CYCLES   = 500;      // long receiver back-pressure
    localparam int SEG_REQS      = 120;
    localparam int NUM_SEGS      = 9;
    localparam int DIR_ROWS      = 32;

    typedef struct packed {
        logic [NUM_W-1:0] granted;
        logic [1:0]       status;
    } grant_rec_t;

    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

    // Directed row. For ROW_CFG, pool carries the register index and number
    // carries the value written.
    typedef struct packed {
        row_kind_t        kind;
        logic             mode;
        logic             pool;
        logic [NUM_W-1:0] number;
        logic             typed;
        logic [NUM_W-1:0] granted;
        logic [1:0]       status;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // fresh maps after reset: first fit starts at number 1
        '{ROW_REQ, MODE_ALLOC, POOL_INODE, 14'd0,     1'b1, 14'd1, ST_OK},
        '{ROW_REQ, MODE_ALLOC, POOL_INODE, 14'd16383, 1'b1, 14'd2, ST_OK},
        // block allocation draws from the block map, not the inode map
        '{ROW_REQ, MODE_ALLOC, POOL_BLOCK, 14'd0,     1'b1, 14'd1, ST_OK},
        '{ROW_REQ, MODE_FREE,  POOL_INODE, 14'd1,     1'b1, 14'd0, ST_OK},
        '{ROW_REQ, MODE_ALLOC, POOL_INODE, 14'd0,     1'b1, 14'd1, ST_OK},
        // number zero is out of range
        '{ROW_REQ, MODE_FREE,  POOL_INODE, 14'd0,     1'b1, 14'd0, ST_RANGE},
        // top of the pool is legal, one past it is not
        '{ROW_REQ, MODE_FREE,  POOL_BLOCK, 14'd8192,  1'b1, 14'd0, ST_OK},
        '{ROW_REQ, MODE_FREE,  POOL_BLOCK, 14'd8193,  1'b1, 14'd0, ST_RANGE},
        '{ROW_REQ, MODE_FREE,  POOL_INODE, 14'd16383, 1'b1, 14'd0, ST_RANGE},
        // freeing an already free number is harmless
        '{ROW_REQ, MODE_FREE,  POOL_INODE, 14'd5,     1'b1, 14'd0, ST_OK},
        // zero limit: nothing to allocate, nothing in range
        '{ROW_CFG, MODE_ALLOC, REG_INODE_LIMIT, 14'd0, 1'b0, 14'd0, ST_OK},
        '{ROW_REQ, MODE_ALLOC, POOL_INODE, 14'd0,     1'b1, 14'd0, ST_FULL},
        '{ROW_REQ, MODE_FREE,  POOL_INODE, 14'd1,     1'b1, 14'd0, ST_RANGE},
        // limit of three, two already taken: one grant then full
        '{ROW_CFG, MODE_ALLOC, REG_INODE_LIMIT, 14'd3, 1'b0, 14'd0, ST_OK},
        '{ROW_REQ, MODE_ALLOC, POOL_INODE, 14'd0,     1'b1, 14'd3, ST_OK},
        '{ROW_REQ, MODE_ALLOC, POOL_INODE, 14'd0,     1'b1, 14'd0, ST_FULL},
        '{ROW_REQ, MODE_FREE,  POOL_INODE, 14'd3,     1'b1, 14'd0, ST_OK},
        '{ROW_REQ, MODE_FREE,  POOL_INODE, 14'd4,     1'b1, 14'd0, ST_RANGE},
        // oversize limit saturates at the map size
        '{ROW_CFG, MODE_ALLOC, REG_BLOCK_LIMIT, 14'd16383, 1'b0, 14'd0, ST_OK},
        '{ROW_REQ, MODE_FREE,  POOL_BLOCK, 14'd8192,  1'b1, 14'd0, ST_OK},
        '{ROW_REQ, MODE_FREE,  POOL_BLOCK, 14'd8193,  1'b1, 14'd0, ST_RANGE},
        '{ROW_REQ, MODE_ALLOC, POOL_BLOCK, 14'd0,     1'b1, 14'd2, ST_OK},
        '{ROW_CFG, MODE_ALLOC, REG_BLOCK_LIMIT, 14'd1, 1'b0, 14'd0, ST_OK},
        '{ROW_REQ, MODE_ALLOC, POOL_BLOCK, 14'd0,     1'b1, 14'd0, ST_FULL},
        '{ROW_REQ, MODE_FREE,  POOL_BLOCK, 14'd1,     1'b1, 14'd0, ST_OK},
        '{ROW_REQ, MODE_ALLOC, POOL_BLOCK, 14'd0,     1'b1, 14'd1, ST_OK},
        // back to full size; the rest is checked by the predictor
        '{ROW_CFG, MODE_ALLOC, REG_INODE_LIMIT, 14'd8192, 1'b0, 14'd0, ST_OK},
        '{ROW_CFG, MODE_ALLOC, REG_BLOCK_LIMIT, 14'd8192, 1'b0, 14'd0, ST_OK},
        '{ROW_REQ, MODE_ALLOC, POOL_INODE, 14'd0,     1'b0, 14'd0, ST_OK},
        '{ROW_REQ, MODE_ALLOC, POOL_BLOCK, 14'd0,     1'b0, 14'd0, ST_OK},
        '{ROW_REQ, MODE_FREE,  POOL_INODE, 14'd2,     1'b0, 14'd0, ST_OK},
        '{ROW_REQ, MODE_ALLOC, POOL_INODE, 14'd0,     1'b0, 14'd0, ST_OK}
    };

    // Limits per random segment, {inode, block}: zero, one, word edges,
    // full size and the saturating maximum all show up.
    localparam logic [NUM_W-1:0] SEG_LIMITS [NUM_SEGS*2] = '{
        14'd64,    14'd200,
        14'd8192,  14'd1,
        14'd0,     14'd130,
        14'd16383, 14'd64,
        14'd65,    14'd8192,
        14'd1,     14'd0,
        14'd128,   14'd16383,
        14'd300,   14'd40,
        14'd8192,  14'd8192
    };

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_mode;
    logic             s_pool;
    logic [NUM_W-1:0] s_number;
    logic             m_valid;
    logic             m_ready;
    logic [NUM_W-1:0] m_granted;
    logic [1:0]       m_status;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    bitmap_first_free_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_pool    (s_pool),
        .s_number  (s_number),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_granted (m_granted),
        .m_status  (m_status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Shadow of the allocator: one used bit per number, per pool, plus limits.
    bit               used_map [2][MAP_BITS];
    logic [NUM_W-1:0] limit_reg [2];

    grant_rec_t       expected_grants [$];    // oldest first
    logic [NUM_W-1:0] held_nums [2][$];       // numbers currently granted, per pool
    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    bit               rx_hold_req = 1'b0;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Allocate: first clear bit below the effective limit. Free: clear the
    // bit for a 1-based number, or flag it out of range.
    function automatic grant_rec_t apply_request(input logic mode, input logic pool,
                                                 input logic [NUM_W-1:0] number);
        grant_rec_t r;
        int         lim;
        r.granted = '0;
        r.status  = ST_OK;
        lim = (int'(limit_reg[pool]) > MAP_BITS) ? MAP_BITS : int'(limit_reg[pool]);
        if (mode == MODE_ALLOC) begin
            r.status = ST_FULL;
            for (int i = 0; i < lim; i++) begin
                if (!used_map[pool][i]) begin
                    used_map[pool][i] = 1'b1;
                    r.granted = NUM_W'(i + 1);
                    r.status  = ST_OK;
                    break;
                end
            end
        end else if (number == '0 || int'(number) > lim) begin
            r.status = ST_RANGE;
        end else begin
            used_map[pool][int'(number) - 1] = 1'b0;
        end
        return r;
    endfunction

    // Offer one request, starting and ending at a falling edge. valid is only
    // lowered on an idle cycle, so back-to-back requests keep it high.
    task automatic send_req(input logic mode, input logic pool,
                            input logic [NUM_W-1:0] number,
                            input logic typed, input grant_rec_t typed_rec,
                            output grant_rec_t rec);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_pool   <= pool;
        s_number <= number;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge: update the shadow maps in request order
        rec = apply_request(mode, pool, number);
        expected_grants.push_back(typed ? typed_rec : rec);
        @(negedge aclk);
    endtask

    // APB write: setup, then access; pready is waited on even though it is tied high.
    // After the access, psel is dropped before the task returns, keeping back-to-back writes apart.
    task automatic write_limit(input logic reg_idx, input logic [NUM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        limit_reg[reg_idx] = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Every request returns a result, so once the last one is in the block is idle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_grants.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Mostly alloc/free traffic on live numbers, some stray frees.
    task automatic run_segment(input int n_reqs);
        grant_rec_t       rec;
        logic             pool;
        logic [NUM_W-1:0] num;
        int               pick;
        int               idx;
        for (int k = 0; k < n_reqs; k++) begin
            pool = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 52) begin
                // number is ignored on allocate; random bits keep it honest
                send_req(MODE_ALLOC, pool, NUM_W'($urandom_range(0, 16383)), 1'b0, '0, rec);
                if (rec.status == ST_OK) held_nums[pool].push_back(rec.granted);
            end else if (pick < 88 && held_nums[pool].size() != 0) begin
                idx = $urandom_range(0, held_nums[pool].size() - 1);
                send_req(MODE_FREE, pool, held_nums[pool][idx], 1'b0, '0, rec);
                // out of range after a limit change: bit stays set, keep it
                if (rec.status == ST_OK) held_nums[pool].delete(idx);
            end else begin
                case ($urandom_range(0, 2))
                    0: num = '0;
                    1: num = NUM_W'($urandom_range(1, int'(limit_reg[pool]) + 1));
                    default: num = NUM_W'($urandom_range(0, 16383));
                endcase
                send_req(MODE_FREE, pool, num, 1'b0, '0, rec);
            end
        end
    endtask

    // Result side: random ready, or a long hold-off counted here when asked.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Compare each result against the oldest outstanding expectation.
    always @(posedge aclk) begin : check_results
        grant_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected result, expected none, got granted %0d status %0d",
                         $time, m_granted, m_status);
                mismatch_count++;
            end else begin
                want = expected_grants.pop_front();
                if (m_granted !== want.granted) begin
                    $display("%0t: granted mismatch, expected %0d, got %0d",
                             $time, want.granted, m_granted);
                    mismatch_count++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        grant_rec_t rec;
        grant_rec_t typed_rec;
        dir_row_t   row;

        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_mode   = MODE_ALLOC;
        s_pool   = POOL_INODE;
        s_number = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        limit_reg[0] = LIMIT_RESET;
        limit_reg[1] = LIMIT_RESET;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table, sender idles lightly, receiver heavily.
        tx_idle_pct = 37;
        rx_idle_pct = 82;
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_limit(row.pool, row.number);
            end else begin
                typed_rec.granted = row.granted;
                typed_rec.status  = row.status;
                send_req(row.mode, row.pool, row.number, row.typed, typed_rec, rec);
            end
        end
        wait_idle();

        // Random segments: three idling patterns, three limit settings each.
        // Between segments the sender pauses until every result is back.
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg / 3)
                0: begin tx_idle_pct = 37; rx_idle_pct = 82; end
                1: begin tx_idle_pct = 82; rx_idle_pct = 37; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            wait_idle();
            write_limit(REG_INODE_LIMIT, SEG_LIMITS[2*seg]);
            write_limit(REG_BLOCK_LIMIT, SEG_LIMITS[2*seg + 1]);
            // once, stall the result side while requests keep coming so the
            // block backs up and drops s_ready
            if (seg == 6) rx_hold_req = 1'b1;
            run_segment(SEG_REQS);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_grants.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== bitmap_first_free_allocator.f =====
rtl/bffa_pkg.sv
rtl/bffa_map_mem.sv
rtl/bitmap_first_free_allocator.sv
rtl/bffa_checker.sv
tb/sv/bitmap_first_free_allocator_tb.sv
